// ----- rtl/core/rc4_stream_cipher_with_nonce_skip_macros.svh -----
// assertion macros shared by the rc4 cipher modules
`ifndef RC4_STREAM_CIPHER_WITH_NONCE_SKIP_MACROS_SVH
`define RC4_STREAM_CIPHER_WITH_NONCE_SKIP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define RC4SK_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, sampled on clk, off while rst_n is low
`define RC4SK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RC4SK_ASSERT_IMPL(lbl, ante, cons, msg)
`define RC4SK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/rc4sk_pkg.sv -----
// shared types, constants and functions of the rc4 cipher
package rc4sk_pkg;

    localparam int unsigned KEY_BYTES_MAX = 256;
    localparam int unsigned DROP_COUNT    = 3742;

    localparam int ADDR_W = 8;
    localparam int BYTE_W = 8;
    localparam int KCNT_W = 9;
    localparam int IDX_W  = 9;
    localparam int CNT_W  = 16;
    localparam int SKIP_W = 9;

    localparam logic [1:0] FUNC_KEY   = 2'd0;
    localparam logic [1:0] FUNC_NONCE = 2'd1;
    localparam logic [1:0] FUNC_DATA  = 2'd2;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        func;
        byte_t             data_byte;
        logic              last;
        logic [SKIP_W-1:0] skip;
    } cmd_t;

    typedef struct packed {
        logic  busy;
        logic  valid;
        byte_t value;
    } res_t;

    // low bits of n + n>>8 + n>>16 + n>>24, only nine bits survive the mask
    function automatic logic [SKIP_W-1:0] skip_count(input logic [31:0] n);
        logic [SKIP_W-1:0] s;
        s = n[8:0] + n[16:8] + n[24:16] + {1'b0, n[31:24]};
        return s;
    endfunction

endpackage

// ----- rtl/core/rc4sk_ram.sv -----
// single write, single read synchronous ram with registered read data
module rc4sk_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read returns the old contents on an address clash
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/rc4sk_core.sv -----
// rc4 sequencer: key buffer, permutation and backup memories with their control
`include "rc4_stream_cipher_with_nonce_skip_macros.svh"
module rc4sk_core (
    input  logic            clk,
    input  logic            rst_n,
    input  rc4sk_pkg::cmd_t cmd,
    input  logic            res_ready,
    output rc4sk_pkg::res_t res
);
    import rc4sk_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FILL = 4'd1;
    localparam logic [3:0] ST_KS1  = 4'd2;
    localparam logic [3:0] ST_KS2  = 4'd3;
    localparam logic [3:0] ST_KS3  = 4'd4;
    localparam logic [3:0] ST_KS4  = 4'd5;
    localparam logic [3:0] ST_GA   = 4'd6;
    localparam logic [3:0] ST_GB   = 4'd7;
    localparam logic [3:0] ST_GC   = 4'd8;
    localparam logic [3:0] ST_GW   = 4'd9;
    localparam logic [3:0] ST_SAVE = 4'd10;
    localparam logic [3:0] ST_LOAD = 4'd11;

    localparam logic [1:0] MODE_DROP = 2'd0;
    localparam logic [1:0] MODE_SKIP = 2'd1;
    localparam logic [1:0] MODE_DATA = 2'd2;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        mode_reg, mode_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [KCNT_W-1:0] kcnt_reg, kcnt_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [ADDR_W-1:0] si_i_reg, si_i_next;
    logic [ADDR_W-1:0] sv_j_reg, sv_j_next;
    byte_t             si_reg, si_next;
    byte_t             sj_reg, sj_next;
    logic [ADDR_W-1:0] ta_reg, ta_next;
    byte_t             dat_reg, dat_next;

    logic              p_we, s_we, k_we;
    logic [ADDR_W-1:0] p_waddr, p_raddr, s_waddr, s_raddr;
    byte_t             p_wdata, s_wdata, p_rdata, s_rdata, k_rdata;
    logic [KCNT_W-1:0] key_len;
    logic [KCNT_W-1:0] k_plus;
    byte_t             ks;

    rc4sk_ram #(.DEPTH(256), .WIDTH(BYTE_W)) u_perm (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    rc4sk_ram #(.DEPTH(256), .WIDTH(BYTE_W)) u_saved (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    rc4sk_ram #(.DEPTH(256), .WIDTH(BYTE_W)) u_key (
        .clk(clk), .we(k_we), .waddr(kcnt_reg[ADDR_W-1:0]), .wdata(cmd.data_byte),
        .raddr(k_reg), .rdata(k_rdata)
    );

    assign key_len = (kcnt_reg == '0) ? KCNT_W'(1) : kcnt_reg;
    assign k_plus  = {1'b0, k_reg} + KCNT_W'(1);

    // swap writes may not have landed when the output entry was read
    always_comb
    begin
        if (ta_reg == j_reg)
        begin
            ks = si_reg;
        end
        else if (ta_reg == i_reg)
        begin
            ks = sj_reg;
        end
        else
        begin
            ks = p_rdata;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        kcnt_next  = kcnt_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        si_i_next  = si_i_reg;
        sv_j_next  = sv_j_reg;
        si_next    = si_reg;
        sj_next    = sj_reg;
        ta_next    = ta_reg;
        dat_next   = dat_reg;
        p_we       = 1'b0;
        p_waddr    = i_reg;
        p_wdata    = sj_reg;
        p_raddr    = ta_reg;
        s_we       = 1'b0;
        s_waddr    = idx_reg[ADDR_W-1:0] - ADDR_W'(1);
        s_wdata    = p_rdata;
        s_raddr    = idx_reg[ADDR_W-1:0];
        k_we       = 1'b0;
        res.busy   = (state_reg != ST_IDLE);
        res.valid  = 1'b0;
        res.value  = dat_reg ^ ks;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    unique case (cmd.func)
                        FUNC_KEY:
                        begin
                            if (kcnt_reg < KCNT_W'(KEY_BYTES_MAX))
                            begin
                                k_we      = 1'b1;
                                kcnt_next = kcnt_reg + KCNT_W'(1);
                            end
                            if (cmd.last)
                            begin
                                idx_next   = '0;
                                state_next = ST_FILL;
                            end
                        end
                        FUNC_NONCE:
                        begin
                            cnt_next   = CNT_W'(cmd.skip);
                            i_next     = si_i_reg;
                            j_next     = sv_j_reg;
                            idx_next   = '0;
                            state_next = ST_LOAD;
                        end
                        FUNC_DATA:
                        begin
                            dat_next   = cmd.data_byte;
                            mode_next  = MODE_DATA;
                            state_next = ST_GA;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                p_we     = 1'b1;
                p_waddr  = idx_reg[ADDR_W-1:0];
                p_wdata  = idx_reg[ADDR_W-1:0];
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(255))
                begin
                    idx_next   = '0;
                    k_next     = '0;
                    j_next     = '0;
                    state_next = ST_KS1;
                end
            end
            ST_KS1:
            begin
                p_raddr    = idx_reg[ADDR_W-1:0];
                state_next = ST_KS2;
            end
            ST_KS2:
            begin
                si_next    = p_rdata;
                j_next     = j_reg + k_rdata + p_rdata;
                p_raddr    = j_next;
                state_next = ST_KS3;
            end
            ST_KS3:
            begin
                sj_next    = p_rdata;
                p_we       = 1'b1;
                p_waddr    = j_reg;
                p_wdata    = si_reg;
                state_next = ST_KS4;
            end
            ST_KS4:
            begin
                p_we     = 1'b1;
                p_waddr  = idx_reg[ADDR_W-1:0];
                p_wdata  = sj_reg;
                k_next   = (k_plus >= key_len) ? '0 : k_plus[ADDR_W-1:0];
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(255))
                begin
                    idx_next   = '0;
                    i_next     = '0;
                    j_next     = '0;
                    cnt_next   = CNT_W'(DROP_COUNT);
                    mode_next  = MODE_DROP;
                    state_next = ST_GA;
                end
                else
                begin
                    state_next = ST_KS1;
                end
            end
            ST_GA:
            begin
                if (mode_reg != MODE_DATA && cnt_reg == '0)
                begin
                    idx_next   = '0;
                    state_next = (mode_reg == MODE_DROP) ? ST_SAVE : ST_IDLE;
                end
                else
                begin
                    i_next     = i_reg + ADDR_W'(1);
                    p_raddr    = i_next;
                    state_next = ST_GB;
                end
            end
            ST_GB:
            begin
                si_next    = p_rdata;
                j_next     = j_reg + p_rdata;
                p_raddr    = j_next;
                state_next = ST_GC;
            end
            ST_GC:
            begin
                sj_next    = p_rdata;
                p_we       = 1'b1;
                p_waddr    = j_reg;
                p_wdata    = si_reg;
                ta_next    = si_reg + p_rdata;
                p_raddr    = ta_next;
                state_next = ST_GW;
            end
            ST_GW:
            begin
                // hold the read address so the keystream byte stays put while stalled
                p_we = 1'b1;
                if (mode_reg == MODE_DATA)
                begin
                    res.valid = 1'b1;
                    if (res_ready)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_GA;
                end
            end
            ST_SAVE:
            begin
                p_raddr  = idx_reg[ADDR_W-1:0];
                s_we     = (idx_reg != '0);
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(256))
                begin
                    si_i_next  = i_reg;
                    sv_j_next  = j_reg;
                    kcnt_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                p_we     = (idx_reg != '0);
                p_waddr  = idx_reg[ADDR_W-1:0] - ADDR_W'(1);
                p_wdata  = s_rdata;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(256))
                begin
                    mode_next  = MODE_SKIP;
                    state_next = ST_GA;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_DROP;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            kcnt_reg  <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            si_i_reg  <= '0;
            sv_j_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            kcnt_reg  <= kcnt_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            si_i_reg  <= si_i_next;
            sv_j_reg  <= sv_j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg  <= si_next;
        sj_reg  <= sj_next;
        ta_reg  <= ta_next;
        dat_reg <= dat_next;
    end

    `RC4SK_ASSERT_IMPL(a_res_from_data, res.valid,
        state_reg == ST_GW && mode_reg == MODE_DATA, "result outside a data step")
    `RC4SK_ASSERT_IMPL(a_cmd_when_idle, cmd.valid, state_reg == ST_IDLE,
        "item taken while busy")
    `RC4SK_ASSERT_NEXT(a_i_steps, state_reg == ST_GA && state_next == ST_GB,
        i_reg == $past(i_reg) + 8'd1, "index i did not advance")

endmodule

// ----- rtl/core/rc4_stream_cipher_with_nonce_skip.sv -----
// top level of the rc4 stream cipher with keystream drop and nonce skip
// Key bytes (func 0) are buffered one per transfer, up to 256, without stalling.
// The transfer marked last starts the key schedule: fill the permutation, run
// the schedule one entry at a time on the single ported permutation memory,
// drop 3742 keystream bytes, then copy the permutation into the backup memory;
// in_stall is high throughout. A nonce transfer (func 1) restores the backup
// and then skips keystream bytes (0 to 511). A data transfer (func 2) keeps
// in_stall high until its steps are done and the output register has room:
// read perm[i], read perm[j], write one half of the swap while reading the
// output entry, write the other half. The result sits in an output register,
// so the next transfer is taken while it waits. Encryption and decryption are
// the same operation. Func code 3 is ignored. A key must be loaded before any
// nonce or data transfer.
`include "rc4_stream_cipher_with_nonce_skip_macros.svh"
module rc4_stream_cipher_with_nonce_skip (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           func,
    input  rc4sk_pkg::byte_t     data_byte,
    input  logic [31:0]          nonce,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rc4sk_pkg::byte_t     out_byte
);
    import rc4sk_pkg::*;

    cmd_t  cmd;
    res_t  res;
    logic  res_ready;
    logic  out_valid_reg, out_valid_next;
    byte_t out_byte_reg, out_byte_next;

    // the core only looks at the item in the cycle of the transfer
    assign in_stall      = res.busy;
    assign cmd.valid     = in_valid && !res.busy;
    assign cmd.func      = func;
    assign cmd.data_byte = data_byte;
    assign cmd.last      = last;
    assign cmd.skip      = skip_count(nonce);

    rc4sk_core u_core (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .res_ready(res_ready),
        .res(res)
    );

    // output register frees up in the same cycle its byte is taken
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        if (res.valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = res.value;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    `RC4SK_ASSERT_NEXT(a_data_busies, in_valid && !in_stall && func == FUNC_DATA, in_stall,
        "data transfer did not start work")
    `RC4SK_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && out_byte == $past(out_byte), "stalled result changed")
    `RC4SK_ASSERT_NEXT(a_key_no_stall,
        in_valid && !in_stall && func == FUNC_KEY && !last, !in_stall,
        "key byte stalled the input")

endmodule

// ----- bench/tb_top.sv -----
// self-checking testbench for the rc4 stream cipher with keystream drop and nonce skip
module tb_top;
    import rc4sk_pkg::*;

    // func code that the block ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 80000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1750;

    typedef struct {
        logic [1:0]  func;
        byte_t       data_byte;
        logic [31:0] nonce;
        logic        last;
    } item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    byte_t       data_byte;
    logic [31:0] nonce;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    byte_t       out_byte;

    // local copy of the cipher state
    byte_t    ks_perm [256];
    byte_t    ks_saved_perm [256];
    byte_t    ks_key [256];
    int       ks_key_len;
    byte_t    ks_i;
    byte_t    ks_j;
    byte_t    ks_saved_i;
    byte_t    ks_saved_j;

    byte_t    cipher_bytes [$];
    int       error_count;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_request;

    rc4_stream_cipher_with_nonce_skip u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .data_byte (data_byte),
        .nonce     (nonce),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // one keystream step: swap and look up
    function automatic byte_t keystream_next();
        byte_t t;
        ks_i = ks_i + 8'd1;
        ks_j = ks_j + ks_perm[ks_i];
        t = ks_perm[ks_i];
        ks_perm[ks_i] = ks_perm[ks_j];
        ks_perm[ks_j] = t;
        return ks_perm[byte_t'(ks_perm[ks_i] + ks_perm[ks_j])];
    endfunction

    // key schedule over the buffered key, then the fixed drop and the backup
    function automatic void key_schedule();
        int    len;
        int    k;
        byte_t j;
        byte_t t;
        len = (ks_key_len == 0) ? 1 : ks_key_len;
        k = 0;
        j = 8'd0;
        for (int n = 0; n < 256; n++)
            ks_perm[n] = byte_t'(n);
        ks_i = 8'd0;
        ks_j = 8'd0;
        for (int n = 0; n < 256; n++)
        begin
            j = j + ks_key[k] + ks_perm[n];
            t = ks_perm[n];
            ks_perm[n] = ks_perm[j];
            ks_perm[j] = t;
            k = k + 1;
            if (k >= len)
                k = 0;
        end
        for (int n = 0; n < DROP_COUNT; n++)
            void'(keystream_next());
        ks_saved_i = ks_i;
        ks_saved_j = ks_j;
        ks_saved_perm = ks_perm;
        ks_key_len = 0;
    endfunction

    // works out what one accepted transfer does, queues any ciphertext byte
    function automatic void predict_transfer(item_t it);
        logic [31:0] sum;
        unique case (it.func)
            FUNC_KEY:
            begin
                if (ks_key_len < KEY_BYTES_MAX)
                begin
                    ks_key[ks_key_len] = it.data_byte;
                    ks_key_len++;
                end
                if (it.last)
                    key_schedule();
            end
            FUNC_NONCE:
            begin
                sum = it.nonce + (it.nonce >> 8) + (it.nonce >> 16) + (it.nonce >> 24);
                ks_i = ks_saved_i;
                ks_j = ks_saved_j;
                ks_perm = ks_saved_perm;
                for (int n = 0; n < int'(sum & 32'h1ff); n++)
                    void'(keystream_next());
            end
            FUNC_DATA:
                cipher_bytes.push_back(it.data_byte ^ keystream_next());
            default:
                ;
        endcase
    endfunction

    // offers one item, with random idle cycles ahead, and waits for the transfer
    task automatic send_item(item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            func <= 2'($urandom);
            data_byte <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= it.func;
        data_byte <= it.data_byte;
        nonce     <= it.nonce;
        last      <= it.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_transfer(it);
    endtask

    task automatic send_fields(logic [1:0] f, byte_t d, logic [31:0] n, logic l);
        item_t it;
        it.func = f;
        it.data_byte = d;
        it.nonce = n;
        it.last = l;
        send_item(it);
    endtask

    // a key of the given length with random content
    task automatic send_key(int len);
        for (int n = 0; n < len; n++)
            send_fields(FUNC_KEY, 8'($urandom), $urandom, n == len - 1);
    endtask

    // receiver: checks each transfer, then drives the next stall
    initial
    begin
        int held;
        bit hold_done;
        byte_t want;
        held = 0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (cipher_bytes.size() == 0)
                begin
                    $error("out_byte: unexpected transfer, actual %0h", out_byte);
                    error_count++;
                end
                else
                begin
                    want = cipher_bytes.pop_front();
                    if (out_byte !== want)
                    begin
                        $error("out_byte: expected %0h, actual %0h", want, out_byte);
                        error_count++;
                    end
                end
            end
            // long hold-off so that the block fills up and stalls its input
            if (hold_request && !hold_done)
            begin
                out_stall <= 1'b1;
                held++;
                if (held >= HOLD_CYCLES)
                    hold_done = 1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        item_t directed [$];
        int    sent;
        int    rekeys;
        int    msg_len;
        int    pick;

        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_KEY;
        data_byte = 8'd0;
        nonce = 32'd0;
        last = 1'b0;
        out_stall = 1'b0;
        hold_request = 0;
        send_idle_pct = 26;
        recv_idle_pct = 82;
        ks_key_len = 0;
        ks_i = 8'd0;
        ks_j = 8'd0;
        ks_saved_i = 8'd0;
        ks_saved_j = 8'd0;

        // directed table: key first, then field extremes and the odd cases
        directed = '{
            '{FUNC_KEY,    8'h00, 32'h0000_0000, 1'b0},
            '{FUNC_KEY,    8'hff, 32'hffff_ffff, 1'b0},
            '{FUNC_KEY,    8'h5a, 32'h0000_0000, 1'b1},
            // data straight after the schedule, no nonce
            '{FUNC_DATA,   8'h00, 32'h0000_0000, 1'b0},
            '{FUNC_DATA,   8'hff, 32'h0000_0000, 1'b0},
            '{FUNC_NONCE,  8'h00, 32'h0000_0000, 1'b0},
            '{FUNC_DATA,   8'h00, 32'h0000_0000, 1'b0},
            '{FUNC_DATA,   8'hff, 32'hffff_ffff, 1'b1},
            // largest nonce, wrapping sum
            '{FUNC_NONCE,  8'hff, 32'hffff_ffff, 1'b1},
            '{FUNC_DATA,   8'h3c, 32'h0000_0000, 1'b0},
            '{FUNC_UNUSED, 8'hff, 32'hffff_ffff, 1'b1},
            '{FUNC_DATA,   8'hc3, 32'h0000_0000, 1'b1},
            // same nonce again gives the same keystream
            '{FUNC_NONCE,  8'h00, 32'h0000_0000, 1'b0},
            '{FUNC_DATA,   8'h00, 32'h0000_0000, 1'b0},
            '{FUNC_NONCE,  8'h00, 32'h0102_0304, 1'b0},
            '{FUNC_DATA,   8'h80, 32'h0000_0000, 1'b0},
            // one-byte key
            '{FUNC_KEY,    8'h01, 32'h0000_0000, 1'b1},
            '{FUNC_DATA,   8'h7f, 32'h0000_0000, 1'b0},
            '{FUNC_NONCE,  8'h00, 32'h0000_01ff, 1'b0},
            '{FUNC_DATA,   8'h01, 32'h0000_0000, 1'b1}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[n])
            send_item(directed[n]);

        sent = 0;
        rekeys = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= 1200)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request = 1;
            end
            else if (sent >= 600)
            begin
                send_idle_pct = 82;
                recv_idle_pct = 26;
            end
            pick = $urandom_range(0, 99);
            if ((pick < 2 && rekeys < 4) || (sent >= 900 && rekeys == 0))
            begin
                // one key runs past capacity, the others are short
                msg_len = (rekeys == 0) ? 300 : $urandom_range(1, 16);
                send_key(msg_len);
                sent += msg_len;
                rekeys++;
            end
            else if (pick < 85)
            begin
                // well-formed message: nonce then data bytes
                send_fields(FUNC_NONCE, 8'($urandom), $urandom, 1'($urandom));
                msg_len = $urandom_range(1, 40);
                for (int n = 0; n < msg_len; n++)
                    send_fields(FUNC_DATA, 8'($urandom), $urandom, n == msg_len - 1);
                sent += msg_len + 1;
            end
            else if (pick < 93)
            begin
                // data carrying on without a fresh nonce
                send_fields(FUNC_DATA, 8'($urandom), $urandom, 1'($urandom));
                sent++;
            end
            else
                send_fields(FUNC_UNUSED, 8'($urandom), $urandom, 1'($urandom));
        end

        in_valid <= 1'b0;
        while (cipher_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
